### hdl/lrt_pkg.sv
package lrt_pkg;

   // Occupancy and capacity fields are five bits wide.
   localparam int unsigned CountBits = 5;

   // Per-slot status, set by the top level from the entry count.
   typedef struct packed {
      logic valid;  // slot holds a live entry
      logic rear;   // slot holds the least recently used entry
   } lrt_slot_type;

   // Control handed from one cell to the next one toward the rear.
   typedef struct packed {
      logic seen;   // a match was found in this cell or in one nearer the front
      logic valid;  // this cell holds a live entry
      logic drop;   // this cell's entry is evicted and must not move on
   } lrt_link_type;

endpackage

### hdl/lrt_cell.sv
module lrt_cell #(
   parameter int unsigned INDEX_BITS = 32
) (
   input  logic                    clock,
   input  logic                    access,
   input  logic                    evict,
   input  logic [INDEX_BITS-1:0]   lookup,
   input  lrt_pkg::lrt_slot_type   slot,
   input  lrt_pkg::lrt_link_type   link_prev,
   input  logic [INDEX_BITS-1:0]   entry_prev,
   output lrt_pkg::lrt_link_type   link_next,
   output logic [INDEX_BITS-1:0]   entry,
   output logic [INDEX_BITS-1:0]   rear_entry
);

   logic [INDEX_BITS-1:0] entry_ff;
   logic [INDEX_BITS-1:0] entry_in;
   logic                  match;
   logic                  shift;

   assign match = slot.valid && (entry_ff == lookup);

   // On an access, take the neighbor's entry unless a match sits nearer the front,
   // the neighbor holds no live entry or the neighbor is the one being evicted.
   assign shift = access && !link_prev.seen && link_prev.valid && !link_prev.drop;

   always_comb begin
      entry_in = shift ? entry_prev : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link_next.seen  = link_prev.seen | match;
   assign link_next.valid = slot.valid;
   assign link_next.drop  = evict & slot.rear;

   assign entry      = entry_ff;
   assign rear_entry = slot.rear ? entry_ff : '0;

endmodule

### hdl/lru_replacement_tracker_core.sv
// LRU replacement tracker.
// Keeps up to "capacity" block indices ordered from most to least recently
// used, in a row of cells, one entry per cell.
// Request channel: present req_block_index with start high while busy is
// low; the request is taken at that clock edge. One request per cycle.
// Response channel: in the cycle after each request, rsp_valid is high for one
// cycle with rsp_hit, rsp_evicted, rsp_evicted_index and rsp_occupancy.
// Throughput is one request per cycle while busy is low: every cell compares
// its entry with the lookup in parallel and shifts from its neighbor in the
// same cycle, so the match chain down the row sets the cycle time.
// The response is never held off; it must be taken in the cycle it is shown.
// Configuration: write capacity on csr_data with csr_valid; csr_ready is
// always high. A capacity of zero acts as one, above DEPTH as DEPTH.
// Reset (synchronous, active high) empties the list, sets capacity to 16
// and holds busy high until the cycle after reset is released.
module lru_replacement_tracker_core #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned INDEX_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [INDEX_BITS-1:0]            req_block_index,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic                             rsp_evicted,
   output logic [INDEX_BITS-1:0]            rsp_evicted_index,
   output logic [lrt_pkg::CountBits-1:0]    rsp_occupancy,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lrt_pkg::CountBits-1:0]    csr_data
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W =
      ((CNT_W > lrt_pkg::CountBits) ? CNT_W : lrt_pkg::CountBits) + 1;

   // Control state
   logic                          busy_ff;
   logic [lrt_pkg::CountBits-1:0] capacity_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic                          rsp_valid_ff;

   // Response payload
   logic                          hit_ff;
   logic                          evicted_ff;
   logic [INDEX_BITS-1:0]         evicted_index_ff;
   logic [INDEX_BITS-1:0]         evicted_index_in;
   logic [lrt_pkg::CountBits-1:0] occupancy_ff;
   logic [lrt_pkg::CountBits-1:0] occupancy_in;

   logic                          access;
   logic                          hit;
   logic                          evict;
   logic [CMP_W-1:0]              cap_raw;
   logic [CMP_W-1:0]              cap_eff;
   logic [CMP_W-1:0]              occ_wide;
   logic [INDEX_BITS-1:0]         rear_or;

   lrt_pkg::lrt_slot_type         slot       [0:DEPTH-1];
   lrt_pkg::lrt_link_type         link       [0:DEPTH-1];
   logic [INDEX_BITS-1:0]         entry      [0:DEPTH-1];
   logic [INDEX_BITS-1:0]         rear_entry [0:DEPTH-1];
   lrt_pkg::lrt_link_type         link_head;

   assign access    = start && !busy_ff;
   assign csr_ready = 1'b1;

   // Cell zero takes the lookup itself, as if from a live neighbor.
   assign link_head.seen  = 1'b0;
   assign link_head.valid = 1'b1;
   assign link_head.drop  = 1'b0;

   // Clamp the capacity to 1..DEPTH.
   always_comb begin
      cap_raw = CMP_W'(capacity_ff);
      if (cap_raw == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_raw > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end else begin
         cap_eff = cap_raw;
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         assign slot[g].valid = count_ff > CNT_W'(g);
         assign slot[g].rear  = count_ff == CNT_W'(g + 1);

         if (g == 0) begin : g_head
            lrt_cell #(
               .INDEX_BITS (INDEX_BITS)
            ) u_cell (
               .clock      (clock),
               .access     (access),
               .evict      (evict),
               .lookup     (req_block_index),
               .slot       (slot[g]),
               .link_prev  (link_head),
               .entry_prev (req_block_index),
               .link_next  (link[g]),
               .entry      (entry[g]),
               .rear_entry (rear_entry[g])
            );
         end else begin : g_body
            lrt_cell #(
               .INDEX_BITS (INDEX_BITS)
            ) u_cell (
               .clock      (clock),
               .access     (access),
               .evict      (evict),
               .lookup     (req_block_index),
               .slot       (slot[g]),
               .link_prev  (link[g-1]),
               .entry_prev (entry[g-1]),
               .link_next  (link[g]),
               .entry      (entry[g]),
               .rear_entry (rear_entry[g])
            );
         end
      end
   endgenerate

   // The match chain ends at the last cell.
   assign hit   = link[DEPTH-1].seen;
   assign evict = !hit && (CMP_W'(count_ff) >= cap_eff);

   // Only the rear cell drives a nonzero rear entry.
   always_comb begin
      rear_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_or = rear_or | rear_entry[i];
      end
   end

   always_comb begin
      priority if (hit || evict) begin
         count_in = count_ff;
      end else begin
         count_in = CNT_W'(count_ff + 1'b1);
      end
      evicted_index_in = evict ? rear_or : '0;
      occ_wide         = CMP_W'(count_in);
      occupancy_in     = occ_wide[lrt_pkg::CountBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         capacity_ff  <= lrt_pkg::CountBits'(16);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= access;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         if (access) begin
            count_ff <= count_in;
         end
      end
   end

   // Hold the response payload for its strobe cycle.
   always_ff @(posedge clock) begin
      if (access) begin
         hit_ff           <= hit;
         evicted_ff       <= evict;
         evicted_index_ff <= evicted_index_in;
         occupancy_ff     <= occupancy_in;
      end
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted       = evicted_ff;
   assign rsp_evicted_index = evicted_index_ff;
   assign rsp_occupancy     = occupancy_ff;

   // A request answers in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      access |=> rsp_valid)
      else $error("response missing after request");

   // A hit never evicts.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("hit reported together with eviction");

   // No eviction means a zero evicted index.
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted) |-> (rsp_evicted_index == '0))
      else $error("evicted index nonzero without eviction");

   // The list never grows past the row of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count beyond depth");

   // A plain insertion grows the list by exactly one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (access && !hit && !evict) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("insertion did not grow the list by one");

endmodule
